// File: rtl/core/kotrr_pkg.sv
// Shared types and codes for the keyed object table with ring reuse.
package kotrr_pkg;

  localparam int KOTRR_POOL_SLOTS = 16;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] value_in;
  } kotrr_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
  } kotrr_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } kotrr_slot_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic resolve;
  } kotrr_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_busy;
  } kotrr_sts_t;

endpackage

// File: rtl/core/keyed_object_table_ring_reuse.sv
// A request is taken in idle, then scanned, the read pipe drained and the result resolved.
// Requests are taken one at a time: a new one is accepted only after the last has resolved; the scan reads one slot per
//   cycle through the single read port of the slot memory.
// Reset (rst_n, synchronous, active low): a clearing pass writes every slot invalid
//   with in_stall high; ring pointer and output valid clear at once.
module keyed_object_table_ring_reuse
  import kotrr_pkg::*;
#(
  parameter int POOL_SLOTS = KOTRR_POOL_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  kotrr_req_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output kotrr_rsp_t out_data
);

  // Controller and datapath talk only through these two groups.
  kotrr_cmd_t cmd;
  kotrr_sts_t sts;

  // State machine: clear, idle, scan, drain the read pipe, resolve.
  kotrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot memory plus compare, ring pointer and the response register.
  // The response register lets the scan of the next request overlap a
  // response that is still waiting on out_stall.
  kotrr_dpath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/kotrr_dpath.sv
// Datapath: slot memory, scan counter, match compare, ring pointer, result register.
module kotrr_dpath
  import kotrr_pkg::*;
#(
  parameter int POOL_SLOTS = KOTRR_POOL_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  kotrr_cmd_t cmd,
  output kotrr_sts_t sts,
  input  kotrr_req_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output kotrr_rsp_t out_data
);

  localparam int IDXW = $clog2(POOL_SLOTS);
  localparam logic [IDXW-1:0] LAST = IDXW'(POOL_SLOTS - 1);

  kotrr_slot_t mem [POOL_SLOTS];

  kotrr_req_t        req_r;
  logic [IDXW-1:0]   idx_r, idx_nxt;
  kotrr_slot_t       rd_data_r;
  logic [IDXW-1:0]   cmp_idx_r;
  logic              cmp_vld_r;
  logic              hit_r;
  logic [IDXW-1:0]   hit_idx_r;
  logic [31:0]       hit_val_r;
  logic [IDXW-1:0]   ptr_r, ptr_nxt, ptr_inc;
  logic              out_valid_r, out_valid_nxt;
  kotrr_rsp_t        out_data_r;
  kotrr_rsp_t        rsp;

  logic              we;
  logic [IDXW-1:0]   wa;
  kotrr_slot_t       wd;

  assign ptr_inc = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;

  always_comb begin
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.clear || cmd.scan) begin
      idx_nxt = (idx_r == LAST) ? '0 : idx_r + 1'b1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  // Clear-pass write; on resolve, the result and the single table write.
  always_comb begin
    we      = 1'b0;
    wa      = idx_r;
    wd      = '0;
    ptr_nxt = ptr_r;
    rsp     = '{status: ST_MISSING, value_out: 32'd0};
    if (cmd.clear) begin
      we = 1'b1;
    end else if (cmd.resolve) begin
      case (req_r.command)
        CMD_ADD: begin
          if (hit_r) begin
            rsp.status = ST_DUP;
          end else begin
            rsp.status = ST_OK;
            ptr_nxt    = ptr_inc;
            we         = 1'b1;
            wa         = ptr_inc;
            wd         = '{valid: 1'b1, key: req_r.key, value: req_r.value_in};
          end
        end
        CMD_GET: begin
          if (hit_r) begin
            rsp.status    = ST_OK;
            rsp.value_out = hit_val_r;
          end
        end
        CMD_DEL: begin
          if (hit_r) begin
            rsp.status = ST_OK;
            we         = 1'b1;
            wa         = hit_idx_r;
            wd         = '{valid: 1'b0, key: req_r.key, value: hit_val_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resolve) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ptr_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      ptr_r       <= ptr_nxt;
      cmp_vld_r   <= cmd.scan;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmp_vld_r && rd_data_r.valid && (rd_data_r.key == req_r.key)) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    cmp_idx_r <= idx_r;
    if (cmp_vld_r && rd_data_r.valid && (rd_data_r.key == req_r.key)) begin
      hit_idx_r <= cmp_idx_r;
      hit_val_r <= rd_data_r.value;
    end
    if (cmd.resolve) begin
      out_data_r <= rsp;
    end
  end

  assign sts.idx_last = (idx_r == LAST);
  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

// File: rtl/core/kotrr_ctrl.sv
// Controller: sequences clear pass, request load, slot scan and resolve.
module kotrr_ctrl
  import kotrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  kotrr_sts_t sts,
  output kotrr_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_SCAN    = 5'b00100,
    S_DRAIN   = 5'b01000,
    S_RESOLVE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (!sts.out_busy) begin
          cmd.resolve = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: bench/keyed_object_table_ring_reuse_tb.sv
// Self-checking bench for the ring-reuse key/value table: random traffic, shadow table, checks.
module keyed_object_table_ring_reuse_tb;
  import kotrr_pkg::*;

  localparam int SLOTS = KOTRR_POOL_SLOTS;
  // Code 3 is not defined in the package; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1325;
  localparam int KEY_POOL = 24;           // more keys than slots, so the ring evicts
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  kotrr_req_t in_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  kotrr_rsp_t out_data;

  always #6 clk = ~clk;

  keyed_object_table_ring_reuse u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Requests still to be sent, and responses owed by the block (oldest first).
  kotrr_req_t request_queue[$];
  kotrr_rsp_t owed_responses[$];

  // Shadow copy of the table.
  logic        shadow_valid[SLOTS];
  logic [31:0] shadow_key[SLOTS];
  logic [31:0] shadow_value[SLOTS];
  int          ring_slot;

  int cycles = 0;
  int total_requests = 0;
  int accepted = 0;
  int responses = 0;
  int failures = 0;
  int gap_left = 0;
  int stall_left = 0;
  int n_add = 0, n_get = 0, n_del = 0, n_unused = 0;
  int n_dup = 0, n_miss = 0, n_evict = 0;
  kotrr_rsp_t want;

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic kotrr_rsp_t table_response(kotrr_req_t req);
    kotrr_rsp_t rsp;
    int hit;
    rsp.status = ST_MISSING;
    rsp.value_out = '0;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && shadow_key[i] == req.key) hit = i;
    case (req.command)
      CMD_ADD: begin
        n_add++;
        if (hit >= 0) begin
          rsp.status = ST_DUP;
        end else begin
          // Ring moves first, so the first add after reset lands in slot 1.
          ring_slot = (ring_slot + 1) % SLOTS;
          if (shadow_valid[ring_slot]) n_evict++;
          shadow_valid[ring_slot] = 1'b1;
          shadow_key[ring_slot] = req.key;
          shadow_value[ring_slot] = req.value_in;
          rsp.status = ST_OK;
        end
      end
      CMD_GET: begin
        n_get++;
        if (hit >= 0) begin
          rsp.status = ST_OK;
          rsp.value_out = shadow_value[hit];
        end
      end
      CMD_DEL: begin
        n_del++;
        // Freed slot is only reused when the ring comes round to it.
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          rsp.status = ST_OK;
        end
      end
      default: n_unused++;
    endcase
    if (rsp.status == ST_DUP) n_dup++;
    if (rsp.status == ST_MISSING) n_miss++;
    return rsp;
  endfunction

  // Idle length: mostly none or short, now and then long; none at all in quiet windows.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One window in four runs with no idling on either side.
  function automatic bit quiet_window(int cyc);
    return ((cyc / 2000) % 4) == 3;
  endfunction

  task automatic queue_request(logic [1:0] cmd, logic [31:0] key, logic [31:0] val);
    kotrr_req_t r;
    r.command = cmd;
    r.key = key;
    r.value_in = val;
    request_queue.push_back(r);
  endtask

  task automatic note_failure(string what, kotrr_rsp_t exp, kotrr_rsp_t act);
    failures++;
    if (failures <= 10)
      $display("[%0d] %s: expected status %0d value %08h, got status %0d value %08h",
               cycles, what, exp.status, exp.value_out, act.status, act.value_out);
  endtask

  // Request driver. The expected response is worked out at the edge the
  // request is taken, so the shadow table follows acceptance order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      ring_slot = 0;
      for (int i = 0; i < SLOTS; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_key[i] = '0;
        shadow_value[i] = '0;
      end
    end else if (in_valid && !in_stall) begin
      owed_responses.push_back(table_response(in_data));
      accepted <= accepted + 1;
      // Back-to-back: keep valid high and just swap the payload.
      if (request_queue.size() != 0 && pick_gap(quiet_window(cycles)) == 0) begin
        in_data <= request_queue.pop_front();
        gap_left <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_left <= pick_gap(quiet_window(cycles));
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (request_queue.size() != 0) begin
        in_data <= request_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Response monitor and stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        responses <= responses + 1;
        if (owed_responses.size() == 0) begin
          note_failure("response with no request outstanding", '0, out_data);
        end else begin
          want = owed_responses.pop_front();
          if (out_data.status !== want.status || out_data.value_out !== want.value_out)
            note_failure("response mismatch", want, out_data);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet_window(cycles) && $urandom_range(0, 7) == 0) begin
        stall_left <= pick_gap(1'b0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout: %0d of %0d requests taken, %0d responses owed",
               accepted, total_requests, owed_responses.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] key_pool[KEY_POOL];
    int pick;
    logic [1:0] cmd;
    logic [31:0] key;

    // Directed: extreme keys and values, duplicate add, hit and miss on get
    // and delete, get after delete, the unused code, then enough adds to wrap
    // the ring and evict a live entry.
    queue_request(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
    queue_request(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_ADD, 32'h0000_0000, 32'h1234_5678);
    queue_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(CMD_DEL, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(CMD_DEL, 32'h0000_0000, 32'h0000_0000);
    queue_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_ADD, 32'h0000_0000, 32'hA5A5_5A5A);
    for (int i = 0; i < 15; i++)
      queue_request(CMD_ADD, 32'h8000_0000 + i, $urandom);
    queue_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    // Random: mostly keys from a small, slowly changing pool so adds collide
    // and gets and deletes find their targets; some fully random keys.
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 99)
        for (int j = 0; j < 4; j++) key_pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, KEY_POOL - 1)] : $urandom;
      pick = $urandom_range(0, 99);
      cmd = (pick < 40) ? CMD_ADD : (pick < 72) ? CMD_GET : (pick < 95) ? CMD_DEL : CMD_UNUSED;
      queue_request(cmd, key, $urandom);
    end
    total_requests = request_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_requests || owed_responses.size() != 0) @(posedge clk);
    // Give a stray extra response time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d add, %0d get, %0d delete, %0d unused code), %0d responses",
             accepted, n_add, n_get, n_del, n_unused, responses);
    $display("%0d duplicate adds, %0d not-found, %0d evictions, %0d mismatches",
             n_dup, n_miss, n_evict, failures);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kotrr_pkg.sv
rtl/core/kotrr_dpath.sv
rtl/core/kotrr_ctrl.sv
rtl/core/keyed_object_table_ring_reuse.sv
bench/keyed_object_table_ring_reuse_tb.sv
